>>> src/ede_pkg.sv
// ----------------------------------------------------------------------------
// Edit distance engine package
// Shared payload types, systolic token and register indexes.
// ----------------------------------------------------------------------------
package ede_pkg;

  localparam int QUERY_MAX_DEF     = 32;
  localparam int CANDIDATE_MAX_DEF = 255;

  localparam int BYTE_W   = 8;
  localparam int DIST_W   = 8;
  localparam int LEN_W    = 6;
  localparam int CNT_W    = 8;
  localparam int WORD_W   = 64;
  localparam int WORDS    = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_QUERY_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_BYTES_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_BYTES_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_BYTES_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_BYTES_3 = 3'd4;

  localparam logic [DIST_W-1:0] DIST_SAT = '1;

  typedef struct packed {
    logic [BYTE_W-1:0] char_byte;
    logic              last_byte;
    logic              empty_mark;
    logic [7:0]        string_tag;
  } ede_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [7:0]        tag_out;
    logic              too_long;
  } ede_out_t;

  // one request travelling down the cell row
  typedef struct packed {
    logic              vld;       // slot holds a request
    logic              apply;     // byte updates the row
    logic              clr;       // restore row entry after this request
    logic              emit;      // request produces a result
    logic              cap;       // result taken from the cell at the active length
    logic [BYTE_W-1:0] ch;
    logic [DIST_W-1:0] left;      // new value of the previous entry
    logic [DIST_W-1:0] diag;      // old value of the previous entry
    logic [DIST_W-1:0] distance;
    logic              too_long;
    logic [7:0]        tag;
  } ede_tok_t;

endpackage

>>> src/edit_distance_engine.sv
// Path from an accepted byte to out_valid: head token register, cell row, output register.
// Throughput: one byte per cycle while the row advances; each byte steps one cell per cycle down the row.
// The whole row holds while a result waits on out_ready.
// Reset (synchronous, rst_n low): row entry j = j, byte count and overflow cleared,
// query length and query bytes zero.
// ----------------------------------------------------------------------------
// Edit distance engine
// Levenshtein distance of streamed candidates against a configured query,
// computed by a systolic row of cells.
// ----------------------------------------------------------------------------
module edit_distance_engine import ede_pkg::*; #(
  parameter int QUERY_MAX     = QUERY_MAX_DEF,
  parameter int CANDIDATE_MAX = CANDIDATE_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ede_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ede_out_t             out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  localparam logic [LEN_W-1:0] QMAX_LEN = LEN_W'(QUERY_MAX);

  logic [LEN_W-1:0]               len_r;
  logic [WORDS-1:0][WORD_W-1:0]   qword_r;
  logic [WORDS*8-1:0][BYTE_W-1:0] q_bytes;
  logic [LEN_W-1:0]               alen;
  logic                           adv;
  logic                           in_fire;
  logic                           out_valid_r;
  ede_out_t                       out_data_r;
  ede_tok_t                       tok [0:QUERY_MAX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      qword_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        REG_QUERY_LENGTH:  len_r      <= cfg_wdata[LEN_W-1:0];
        REG_QUERY_BYTES_0: qword_r[0] <= cfg_wdata;
        REG_QUERY_BYTES_1: qword_r[1] <= cfg_wdata;
        REG_QUERY_BYTES_2: qword_r[2] <= cfg_wdata;
        REG_QUERY_BYTES_3: qword_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign q_bytes = qword_r;
  assign alen    = (len_r > QMAX_LEN) ? QMAX_LEN : len_r;

  // advance the row unless a result is held
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign in_fire  = in_valid && adv;

  ede_head #(
    .CANDIDATE_MAX(CANDIDATE_MAX)
  ) u_head (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_fire (in_fire),
    .in_data (in_data),
    .alen    (alen),
    .tok_out (tok[0])
  );

  for (genvar j = 1; j <= QUERY_MAX; j++) begin : g_cell
    ede_cell #(
      .IDX(j)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .qbyte   (q_bytes[j-1]),
      .alen    (alen),
      .tok_in  (tok[j-1]),
      .tok_out (tok[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tok[QUERY_MAX].vld && tok[QUERY_MAX].emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.distance <= tok[QUERY_MAX].distance;
      out_data_r.tag_out  <= tok[QUERY_MAX].tag;
      out_data_r.too_long <= tok[QUERY_MAX].too_long;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/ede_head.sv
// ----------------------------------------------------------------------------
// Edit distance head cell
// Holds entry zero of the row (the byte count) and the overflow flag, and
// turns each accepted request into a token for the cell row.
// ----------------------------------------------------------------------------
module ede_head import ede_pkg::*; #(
  parameter int CANDIDATE_MAX = CANDIDATE_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_fire,
  input  ede_in_t          in_data,
  input  logic [LEN_W-1:0] alen,
  output ede_tok_t         tok_out
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CANDIDATE_MAX);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  ede_tok_t         tok_r, tok_nxt;

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    tok_nxt   = '0;
    tok_nxt.tag = in_data.string_tag;
    tok_nxt.ch  = in_data.char_byte;
    if (in_fire) begin
      tok_nxt.vld = 1'b1;
      if (in_data.empty_mark) begin
        tok_nxt.clr      = 1'b1;
        tok_nxt.emit     = 1'b1;
        tok_nxt.distance = DIST_W'(alen);
        count_nxt        = '0;
        ovf_nxt          = 1'b0;
      end else if (count_r < CNT_MAX) begin
        tok_nxt.apply    = 1'b1;
        tok_nxt.clr      = in_data.last_byte;
        tok_nxt.emit     = in_data.last_byte;
        tok_nxt.cap      = in_data.last_byte && (alen != '0);
        tok_nxt.diag     = count_r;
        tok_nxt.left     = count_r + 1'b1;
        tok_nxt.distance = count_r + 1'b1;
        count_nxt        = in_data.last_byte ? '0 : count_r + 1'b1;
        ovf_nxt          = 1'b0;
      end else begin
        // byte beyond the bound: drop it, remember the overflow
        tok_nxt.clr      = in_data.last_byte;
        tok_nxt.emit     = in_data.last_byte;
        tok_nxt.distance = DIST_SAT;
        tok_nxt.too_long = 1'b1;
        count_nxt        = in_data.last_byte ? '0 : count_r;
        ovf_nxt          = !in_data.last_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      tok_r   <= '0;
    end else if (adv) begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

>>> src/ede_cell.sv
// ----------------------------------------------------------------------------
// Edit distance row cell
// Holds one row entry and one query byte position; applies the edit
// recurrence to each passing byte and hands the token on.
// ----------------------------------------------------------------------------
module ede_cell import ede_pkg::*; #(
  parameter int IDX = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [BYTE_W-1:0] qbyte,
  input  logic [LEN_W-1:0]  alen,
  input  ede_tok_t          tok_in,
  output ede_tok_t          tok_out
);

  localparam logic [DIST_W-1:0] ROW_INIT = DIST_W'(IDX);
  localparam logic [LEN_W-1:0]  MY_IDX   = LEN_W'(IDX);

  logic [DIST_W-1:0] row_r, row_nxt;
  ede_tok_t          tok_r, tok_nxt;
  logic [DIST_W:0]   up_p1, left_p1, diag_c, m1, vmin;
  logic [DIST_W-1:0] vsat;

  always_comb begin
    up_p1   = {1'b0, row_r} + 1'b1;
    left_p1 = {1'b0, tok_in.left} + 1'b1;
    diag_c  = {1'b0, tok_in.diag} + {{DIST_W{1'b0}}, (qbyte != tok_in.ch)};
    m1      = (up_p1 < left_p1) ? up_p1 : left_p1;
    vmin    = (m1 < diag_c) ? m1 : diag_c;
    vsat    = vmin[DIST_W] ? DIST_SAT : vmin[DIST_W-1:0];
  end

  always_comb begin
    row_nxt      = row_r;
    tok_nxt      = tok_in;
    tok_nxt.left = vsat;
    tok_nxt.diag = row_r;
    if (tok_in.vld) begin
      if (tok_in.clr) begin
        row_nxt = ROW_INIT;
      end else if (tok_in.apply) begin
        row_nxt = vsat;
      end
      if (tok_in.cap && (alen == MY_IDX)) begin
        tok_nxt.distance = vsat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= ROW_INIT;
      tok_r <= '0;
    end else if (adv) begin
      row_r <= row_nxt;
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

>>> dv/edit_distance_engine_test.sv
// ----------------------------------------------------------------------------
// Edit distance engine testbench
// Streams candidate strings against a sequence of query settings. A local
// model of the dynamic-programming row predicts each distance, and every
// result is checked in order against that prediction.
// ----------------------------------------------------------------------------
module edit_distance_engine_test;
  import ede_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = QUERY_MAX_DEF + 10;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 65;

  typedef enum int {EDIT_SUB, EDIT_INS, EDIT_DEL} edit_kind_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  ede_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  ede_out_t             out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = REG_QUERY_LENGTH;
  logic [WORD_W-1:0]    cfg_wdata = '0;

  // model of the query registers and the distance row
  logic [LEN_W-1:0]  query_len;
  logic [WORD_W-1:0] query_words [WORDS];
  logic [DIST_W-1:0] edit_row [QUERY_MAX_DEF+1];
  int                bytes_seen;
  bit                overflow_seen;

  ede_in_t  pending_requests[$];
  ede_out_t expected_distances[$];
  logic [7:0] cand_text[$];

  bit no_idle        = 1'b0;
  int error_count    = 0;
  int accepted_count = 0;
  int queued_count   = 0;
  int checked_count  = 0;
  int query_count    = 0;

  edit_distance_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void clear_edit_row();
    for (int j = 0; j <= QUERY_MAX_DEF; j++) edit_row[j] = DIST_W'(j);
    bytes_seen    = 0;
    overflow_seen = 1'b0;
  endfunction

  function automatic int active_len();
    return (query_len > QUERY_MAX_DEF) ? QUERY_MAX_DEF : int'(query_len);
  endfunction

  function automatic logic [7:0] query_byte(input int i);
    return query_words[i / 8][(i % 8) * 8 +: 8];
  endfunction

  // Advance the row by one request and queue the distance it finishes, if any
  function automatic void advance_edit_row(input ede_in_t req);
    ede_out_t res;
    int diag, left, up, v, alen;
    alen        = active_len();
    res         = '0;
    res.tag_out = req.string_tag;
    if (req.empty_mark) begin
      res.distance = DIST_W'(alen);
      expected_distances.push_back(res);
      clear_edit_row();
    end else begin
      if (bytes_seen < CANDIDATE_MAX_DEF) begin
        diag        = int'(edit_row[0]);
        left        = bytes_seen + 1;
        edit_row[0] = DIST_W'(left);
        for (int j = 1; j <= QUERY_MAX_DEF; j++) begin
          up = int'(edit_row[j]);
          v  = diag + ((query_byte(j - 1) != req.char_byte) ? 1 : 0);
          if (up + 1 < v) v = up + 1;
          if (left + 1 < v) v = left + 1;
          if (v > 255) v = 255;
          edit_row[j] = DIST_W'(v);
          diag = up;
          left = v;
        end
        bytes_seen++;
      end else begin
        overflow_seen = 1'b1;
      end
      if (req.last_byte) begin
        if (overflow_seen) begin
          res.distance = DIST_SAT;
          res.too_long = 1'b1;
        end else begin
          res.distance = edit_row[alen];
        end
        expected_distances.push_back(res);
        clear_edit_row();
      end
    end
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    int alen;
    alen = active_len();
    if (alen > 0 && $urandom_range(0, 1) == 1) return query_byte($urandom_range(0, alen - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic void push_req(input logic [7:0] ch, input bit last, input bit empty,
                                   input logic [7:0] tag);
    ede_in_t req;
    req.char_byte  = ch;
    req.last_byte  = last;
    req.empty_mark = empty;
    req.string_tag = tag;
    pending_requests.push_back(req);
    queued_count++;
  endfunction

  // Queue cand_text as one candidate; an empty text becomes an empty marker
  function automatic void push_candidate(input bit finish, input bit noisy,
                                         input logic [7:0] tag);
    if (cand_text.size() == 0) begin
      push_req(8'($urandom), 1'($urandom), 1'b1, tag);
    end else begin
      foreach (cand_text[i]) begin
        // now and then abandon the partial candidate with an empty marker
        if (noisy && i > 0 && $urandom_range(0, 59) == 0)
          push_req(8'($urandom), 1'($urandom), 1'b1, 8'($urandom));
        push_req(cand_text[i], finish && (i == cand_text.size() - 1), 1'b0, tag);
      end
    end
  endfunction

  function automatic void set_text(input string s);
    cand_text.delete();
    for (int i = 0; i < s.len(); i++) cand_text.push_back(s[i]);
  endfunction

  function automatic void queue_random_phase(input int n_items, input bit open_end);
    int start, kind, pos;
    start = pending_requests.size();
    while (pending_requests.size() - start < n_items) begin
      kind = $urandom_range(0, 99);
      cand_text.delete();
      if (kind < 55) begin
        // near misses: the query with a few random edits
        for (int i = 0; i < active_len(); i++) cand_text.push_back(query_byte(i));
        repeat ($urandom_range(0, 3)) begin
          pos = $urandom_range(0, cand_text.size());
          case (edit_kind_e'($urandom_range(0, 2)))
            EDIT_SUB: if (pos < cand_text.size()) cand_text[pos] = pick_byte();
            EDIT_INS: cand_text.insert(pos, pick_byte());
            default:  if (pos < cand_text.size()) cand_text.delete(pos);
          endcase
        end
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 40)) cand_text.push_back(pick_byte());
      end
      push_candidate(1'b1, 1'b1, 8'($urandom));
    end
    if (open_end) begin
      // leave a candidate half sent across the next query change
      cand_text.delete();
      repeat (4) cand_text.push_back(pick_byte());
      push_candidate(1'b0, 1'b0, 8'($urandom));
    end
  endfunction

  function automatic void queue_long_candidate(input int n_bytes);
    cand_text.delete();
    repeat (n_bytes) cand_text.push_back(pick_byte());
    push_candidate(1'b1, 1'b0, 8'($urandom));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_QUERY_LENGTH:  query_len      = value[LEN_W-1:0];
      REG_QUERY_BYTES_0: query_words[0] = value;
      REG_QUERY_BYTES_1: query_words[1] = value;
      REG_QUERY_BYTES_2: query_words[2] = value;
      REG_QUERY_BYTES_3: query_words[3] = value;
      default: ;
    endcase
  endtask

  task automatic load_query(input logic [LEN_W-1:0] len, input logic [WORD_W-1:0] w0,
                            input logic [WORD_W-1:0] w1, input logic [WORD_W-1:0] w2,
                            input logic [WORD_W-1:0] w3);
    write_reg(REG_QUERY_LENGTH, WORD_W'(len));
    write_reg(REG_QUERY_BYTES_0, w0);
    write_reg(REG_QUERY_BYTES_1, w1);
    write_reg(REG_QUERY_BYTES_2, w2);
    write_reg(REG_QUERY_BYTES_3, w3);
    cfg_wr_en <= 1'b0;
    query_count++;
  endtask

  // Hold until every request is in and every distance is out, then let the row drain
  task automatic wait_idle();
    while (accepted_count != queued_count || expected_distances.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_requests
    int gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        advance_edit_row(in_data);
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          in_data  <= pending_requests.pop_front();
          in_valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : collect_distances
    int stall_left;
    ede_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_distances.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result distance=%0d tag=%0d too_long=%0b",
                   $time, out_data.distance, out_data.tag_out, out_data.too_long);
        end else begin
          want = expected_distances.pop_front();
          checked_count++;
          if (out_data.distance !== want.distance || out_data.tag_out !== want.tag_out ||
              out_data.too_long !== want.too_long) begin
            error_count++;
            $display("%0t: mismatch exp dist=%0d tag=%0d tl=%0b, got dist=%0d tag=%0d tl=%0b",
                     $time, want.distance, want.tag_out, want.too_long,
                     out_data.distance, out_data.tag_out, out_data.too_long);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("%0t: nothing moved for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stimulus
    query_len = '0;
    foreach (query_words[i]) query_words[i] = '0;
    clear_edit_row();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: query "hello"
    load_query(LEN_W'(5), 64'h0000_006F_6C6C_6568, '1, '0, '1);
    push_req(8'hA5, 1'b0, 1'b1, 8'h00);
    push_req(8'hFF, 1'b1, 1'b1, 8'hFF);
    set_text("hello");
    push_candidate(1'b1, 1'b0, 8'h01);
    push_req(8'h00, 1'b1, 1'b0, 8'h02);
    set_text("he");
    push_candidate(1'b0, 1'b0, 8'h03);
    push_req(8'h00, 1'b0, 1'b1, 8'h03);
    set_text("helo");
    push_candidate(1'b1, 1'b0, 8'h04);
    set_text("helloo");
    push_candidate(1'b1, 1'b0, 8'h05);
    set_text("hell");
    cand_text.push_back(8'hFF);
    push_candidate(1'b1, 1'b0, 8'h06);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      no_idle = (p % 3 == 2);
      case (p)
        0:       load_query(LEN_W'(0), rand_word(), rand_word(), rand_word(), rand_word());
        1:       load_query(LEN_W'(32), rand_word(), rand_word(), rand_word(), rand_word());
        2:       load_query(LEN_W'(63), '1, '0, rand_word(), rand_word());
        3:       load_query(LEN_W'(33), rand_word(), rand_word(), rand_word(), rand_word());
        default: load_query(LEN_W'($urandom_range(1, 31)), rand_word(), rand_word(),
                            rand_word(), rand_word());
      endcase
      queue_random_phase(PHASE_ITEMS, p == 3);
      if (p == 1) queue_long_candidate(CANDIDATE_MAX_DEF);
      if (p == 2) queue_long_candidate(CANDIDATE_MAX_DEF + 2);
      wait_idle();
    end

    $display("Run covered %0d requests and %0d checked distances over %0d query settings,",
             accepted_count, checked_count, query_count);
    $display("with query lengths 0 to 63, empty and abandoned candidates, and overlong ones.");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
